// ===== src/htfd_pkg.sv =====
`timescale 1ns / 1ps

package htfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;

    // Scale factors: result = floor(SCALE * raw / 65535), temperature offset after.
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    localparam int TEMP_PROD_W = 31;
    localparam int HUM_PROD_W  = 30;

    // One decoded frame, passed from front to back.
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
        logic        temp_crc_ok;
        logic        hum_crc_ok;
    } t_frame;

    // CRC-8, MSB first, one byte.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/htfd_if.sv =====
`timescale 1ns / 1ps

interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic        [13:0] humidity_centi;
    logic        [15:0] raw_temperature;
    logic        [15:0] raw_humidity;
    logic               temp_crc_ok;
    logic               hum_crc_ok;

    modport source (output valid, output temperature_centi, output humidity_centi,
                    output raw_temperature, output raw_humidity, output temp_crc_ok,
                    output hum_crc_ok, input ready);
    modport sink   (input valid, input temperature_centi, input humidity_centi,
                    input raw_temperature, input raw_humidity, input temp_crc_ok,
                    input hum_crc_ok, output ready);
endinterface

// ===== src/humidity_temp_frame_decoder.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Beat carries
// -------  ---  ----------------------------------------------------------
// i_in     in   rx_byte (8), frame_start (1): one byte of a six-byte frame
// o_out    out  temperature_centi (s15), humidity_centi (14), raw words
//                (16 + 16), temp_crc_ok, hum_crc_ok: one beat per frame
//
// One input beat per cycle while the frame queue has room; the front tracks
// byte position and CRC as each byte is taken. After the edge that takes a
// frame's sixth byte, o_out.valid follows once the frame has passed the queue
// (written on that edge), the multiply stage and the divide/output register.
// Reset is synchronous, active low; it clears position, CRC and all valids.
// i_in stalls only when the two-entry frame queue is full, i.e. when the
// consumer has held o_out.ready low long enough to back up the pipeline.

module humidity_temp_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htfd_in_if.sink    i_in,
    htfd_out_if.source o_out
);
    import htfd_pkg::*;

    t_frame front_frame;
    t_frame fifo_frame;
    logic   front_push;
    logic   fifo_full;
    logic   fifo_valid;
    logic   back_pop;

    // Byte assembly and CRC check
    htfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_fifo_full (fifo_full),
        .o_push      (front_push),
        .o_frame     (front_frame)
    );

    // Decouples frame capture from scaling
    htfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_frame),
        .i_pop   (back_pop),
        .o_rdata (fifo_frame),
        .o_full  (fifo_full),
        .o_valid (fifo_valid)
    );

    // Scaling: constant multiply, then divide by 65535 with one correction
    htfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fifo_valid),
        .i_frame (fifo_frame),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );

endmodule

// ===== src/htfd_front.sv =====
`timescale 1ns / 1ps

module htfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htfd_in_if.sink          i_in,
    input  logic             i_fifo_full,
    output logic             o_push,
    output htfd_pkg::t_frame o_frame
);
    import htfd_pkg::*;

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_tok, n_tok;

    logic [2:0]  pos;
    logic [7:0]  crc_in;
    logic [7:0]  crc_next;
    logic        beat;

    assign i_in.ready = !i_fifo_full;
    assign beat       = i_in.valid && i_in.ready;

    // frame_start and the unused codes both land on the first byte
    assign pos = (i_in.frame_start || r_pos > POS_H_CRC) ? POS_T_HI : r_pos;

    assign crc_in   = (pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : r_crc;
    assign crc_next = crc8_feed(crc_in, i_in.rx_byte);

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_temp = r_temp;
        n_hum  = r_hum;
        n_tok  = r_tok;
        o_push = 1'b0;
        if (beat) begin
            case (pos)
                POS_T_HI: begin
                    n_crc  = crc_next;
                    n_temp = {i_in.rx_byte, 8'h00};
                    n_pos  = POS_T_LO;
                end
                POS_T_LO: begin
                    n_crc  = crc_next;
                    n_temp = {r_temp[15:8], i_in.rx_byte};
                    n_pos  = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_tok  = (r_crc == i_in.rx_byte);
                    n_crc  = CRC_INIT;
                    n_pos  = POS_H_HI;
                end
                POS_H_HI: begin
                    n_crc  = crc_next;
                    n_hum  = {i_in.rx_byte, 8'h00};
                    n_pos  = POS_H_LO;
                end
                POS_H_LO: begin
                    n_crc  = crc_next;
                    n_hum  = {r_hum[15:8], i_in.rx_byte};
                    n_pos  = POS_H_CRC;
                end
                default: begin
                    o_push = 1'b1;
                    n_crc  = CRC_INIT;
                    n_pos  = POS_T_HI;
                end
            endcase
        end
    end

    assign o_frame.raw_temperature = r_temp;
    assign o_frame.raw_humidity    = r_hum;
    assign o_frame.temp_crc_ok     = r_tok;
    assign o_frame.hum_crc_ok      = (r_crc == i_in.rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_T_HI;
            r_crc  <= CRC_INIT;
            r_temp <= 16'h0000;
            r_hum  <= 16'h0000;
            r_tok  <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_temp <= n_temp;
            r_hum  <= n_hum;
            r_tok  <= n_tok;
        end
    end

endmodule

// ===== src/htfd_fifo.sv =====
`timescale 1ns / 1ps

module htfd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  htfd_pkg::t_frame i_wdata,
    input  logic             i_pop,
    output htfd_pkg::t_frame o_rdata,
    output logic             o_full,
    output logic             o_valid
);
    import htfd_pkg::*;

    t_frame     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_rdata = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/htfd_back.sv =====
`timescale 1ns / 1ps

module htfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  htfd_pkg::t_frame i_frame,
    output logic             o_pop,
    htfd_out_if.source       o_out
);
    import htfd_pkg::*;

    // stage 1: scale products
    logic                   r_s1_valid;
    logic [TEMP_PROD_W-1:0] r_s1_tx;
    logic [HUM_PROD_W-1:0]  r_s1_hx;
    t_frame                 r_s1_frame;

    // stage 2: output register
    logic               r_o_valid;
    logic signed [14:0] r_temp_centi;
    logic        [13:0] r_hum_centi;
    t_frame             r_o_frame;

    logic adv1;
    logic adv2;

    // divide by 65535: x>>16 is the quotient or one short of it
    logic [14:0] t_q0;
    logic [16:0] t_r0;
    logic [14:0] t_q;
    logic [13:0] h_q0;
    logic [16:0] h_r0;
    logic [13:0] h_q;

    assign adv2  = !r_o_valid || o_out.ready;
    assign adv1  = !r_s1_valid || adv2;
    assign o_pop = adv1 && i_valid;

    assign t_q0 = r_s1_tx[TEMP_PROD_W-1:16];
    assign t_r0 = {1'b0, r_s1_tx[15:0]} + {2'b00, t_q0};
    assign t_q  = t_q0 + {14'd0, (t_r0 >= FULL_SCALE)};

    assign h_q0 = r_s1_hx[HUM_PROD_W-1:16];
    assign h_r0 = {1'b0, r_s1_hx[15:0]} + {3'b000, h_q0};
    assign h_q  = h_q0 + {13'd0, (h_r0 >= FULL_SCALE)};

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_tx    <= {16'd0, TEMP_SCALE} * {15'd0, i_frame.raw_temperature};
            r_s1_hx    <= {16'd0, HUM_SCALE} * {14'd0, i_frame.raw_humidity};
            r_s1_frame <= i_frame;
        end
        if (adv2) begin
            r_temp_centi <= signed'(t_q - TEMP_OFFSET);
            r_hum_centi  <= h_q;
            r_o_frame    <= r_s1_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_valid <= i_valid;
            end
            if (adv2) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    assign o_out.valid             = r_o_valid;
    assign o_out.temperature_centi = r_temp_centi;
    assign o_out.humidity_centi    = r_hum_centi;
    assign o_out.raw_temperature   = r_o_frame.raw_temperature;
    assign o_out.raw_humidity      = r_o_frame.raw_humidity;
    assign o_out.temp_crc_ok       = r_o_frame.temp_crc_ok;
    assign o_out.hum_crc_ok        = r_o_frame.hum_crc_ok;

endmodule
